>>> rtl/cfp_pkg.sv
// shared types and constants for the converter fault protection block
`timescale 1ns / 1ps
`default_nettype none
package cfp_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_LIMIT     = 3'd0,
    CFG_IN_CURRENT_LIMIT  = 3'd1,
    CFG_IN_VOLTAGE_LIMIT  = 3'd2,
    CFG_OUT_VOLTAGE_LIMIT = 3'd3,
    CFG_CURRENT_NOMINAL   = 3'd4,
    CFG_INTEGRAL_LIMIT    = 3'd5,
    CFG_CURRENT_GAIN      = 3'd6,
    CFG_SAMPLE_PERIOD     = 3'd7
  } cfg_idx_t;

  localparam logic signed [31:0] CURRENT_LIMIT_RST     = 32'sd524288;
  localparam logic signed [31:0] IN_CURRENT_LIMIT_RST  = 32'sd196608;
  localparam logic signed [31:0] IN_VOLTAGE_LIMIT_RST  = 32'sd5898240;
  localparam logic signed [31:0] OUT_VOLTAGE_LIMIT_RST = 32'sd6553600;
  localparam logic signed [31:0] CURRENT_NOMINAL_RST   = 32'sd393216;
  localparam logic signed [31:0] INTEGRAL_LIMIT_RST    = 32'sd3932160;
  localparam logic signed [31:0] CURRENT_GAIN_RST      = 32'sd130;
  localparam logic [16:0]        SAMPLE_PERIOD_RST     = 17'd3;

  typedef enum logic [2:0] {
    OP_IL   = 3'd0,
    OP_IIN  = 3'd1,
    OP_VIN  = 3'd2,
    OP_VOUT = 3'd3,
    OP_INT  = 3'd4
  } op_t;

  typedef struct packed {
    logic [11:0] adc_out_voltage;
    logic [11:0] adc_coil_current;
    logic [11:0] adc_in_voltage;
    logic [11:0] adc_in_current;
  } in_t;

  typedef struct packed {
    logic [3:0]         fault_bits;
    logic               pwm_off;
    logic               integral_trip;
    logic signed [31:0] coil_current;
    logic [30:0]        integral_value;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    op_t  mul_op;
    logic post_en;
    op_t  post_op;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/cfp_ctrl.sv
// sequencer that steps one sample set through the shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module cfp_ctrl
  import cfp_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IL,
    S_IIN,
    S_VIN,
    S_VOUT,
    S_INT,
    S_SUM,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   take;

  always_comb begin
    in_stall = !((state_r == S_IDLE) || ((state_r == S_FIN) && sts.out_free));
    take     = in_valid && !in_stall;

    cmd         = '0;
    cmd.load    = take;
    cmd.mul_op  = OP_IL;
    cmd.post_op = OP_IL;
    state_nxt   = state_r;

    case (state_r)
      S_IDLE: begin
        if (take) state_nxt = S_IL;
      end
      S_IL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_IL;
        state_nxt  = S_IIN;
      end
      S_IIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = OP_IIN;
        cmd.post_en = 1'b1;
        cmd.post_op = OP_IL;
        state_nxt   = S_VIN;
      end
      S_VIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = OP_VIN;
        cmd.post_en = 1'b1;
        cmd.post_op = OP_IIN;
        state_nxt   = S_VOUT;
      end
      S_VOUT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = OP_VOUT;
        cmd.post_en = 1'b1;
        cmd.post_op = OP_VIN;
        state_nxt   = S_INT;
      end
      S_INT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = OP_INT;
        cmd.post_en = 1'b1;
        cmd.post_op = OP_VOUT;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.post_en = 1'b1;
        cmd.post_op = OP_INT;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = take ? S_IL : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cfp_datapath.sv
// scaling, limit checks, integrator and result register
`timescale 1ns / 1ps
`default_nettype none
module cfp_datapath
  import cfp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata,
  input  in_t                  in_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  wire                  out_stall,
  output out_t                 out_data
);

  localparam longint OutVoltMag   = ((longint'(11) <<< FRAC_BITS) + 2925) / 5850;
  localparam longint OutVoltOfs   = ((longint'(502) <<< FRAC_BITS) + 2) / 5;
  localparam longint InVoltGainL  = ((longint'(12491) <<< FRAC_BITS) + 250000) / 500000;
  localparam longint InCurGainL   = ((longint'(9897) <<< FRAC_BITS) + 5000000) / 10000000;

  localparam logic signed [32:0] OutVoltGain   = 33'(-OutVoltMag);
  localparam logic signed [32:0] InVoltGain    = 33'(InVoltGainL);
  localparam logic signed [32:0] InCurGain     = 33'(InCurGainL);
  localparam logic signed [51:0] OutVoltOffset = 52'(OutVoltOfs);

  localparam logic signed [51:0] S32Max = 52'sd2147483647;
  localparam logic signed [51:0] S32Min = -52'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > S32Max) begin
      r = 32'sh7fffffff;
    end else if (v < S32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic signed [31:0] current_limit_r;
  logic signed [31:0] in_current_limit_r;
  logic signed [31:0] in_voltage_limit_r;
  logic signed [31:0] out_voltage_limit_r;
  logic signed [31:0] current_nominal_r;
  logic signed [31:0] integral_limit_r;
  logic signed [31:0] current_gain_r;
  logic [16:0]        sample_period_r;

  // working registers
  in_t                smp_r;
  logic signed [50:0] prod_r;
  logic signed [50:0] prod_nxt;
  logic signed [31:0] il_r;
  logic signed [32:0] diff_r;
  logic [30:0]        sum_r;
  logic [30:0]        sum_nxt;

  // architectural state
  logic [30:0] integ_r;
  logic [30:0] integ_nxt;
  logic [3:0]  fault_r;
  logic [3:0]  fault_nxt;
  logic        pwm_r;
  logic        pwm_nxt;

  logic        out_valid_r;
  out_t        out_r;
  out_t        out_nxt;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_a_ext;
  logic signed [50:0] mul_b_ext;

  logic signed [51:0] post_in;
  logic signed [31:0] post_val;
  logic signed [31:0] post_lim;
  logic               post_over;
  logic signed [50:0] int_term;
  logic signed [51:0] int_sum;
  logic               trip;

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      OP_IL: begin
        mul_a = 33'(current_gain_r);
        mul_b = $signed({6'd0, smp_r.adc_coil_current});
      end
      OP_IIN: begin
        mul_a = InCurGain;
        mul_b = $signed({6'd0, smp_r.adc_in_current});
      end
      OP_VIN: begin
        mul_a = InVoltGain;
        mul_b = $signed({6'd0, smp_r.adc_in_voltage});
      end
      OP_VOUT: begin
        mul_a = OutVoltGain;
        mul_b = $signed({6'd0, smp_r.adc_out_voltage});
      end
      OP_INT: begin
        mul_a = diff_r;
        mul_b = $signed({1'b0, sample_period_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_a_ext = 51'(mul_a);
    mul_b_ext = 51'(mul_b);
    prod_nxt  = mul_a_ext * mul_b_ext;
  end

  // product post-processing
  always_comb begin
    if (cmd.post_op == OP_VOUT) begin
      post_in = 52'(prod_r) + OutVoltOffset;
    end else begin
      post_in = 52'(prod_r);
    end
    post_val = sat32(post_in);

    case (cmd.post_op)
      OP_IL:   post_lim = current_limit_r;
      OP_IIN:  post_lim = in_current_limit_r;
      OP_VIN:  post_lim = in_voltage_limit_r;
      OP_VOUT: post_lim = out_voltage_limit_r;
      default: post_lim = 32'sh7fffffff;
    endcase
    post_over = cmd.post_en && (cmd.post_op != OP_INT) && (post_val > post_lim);

    // arithmetic shift rounds toward minus infinity
    int_term = prod_r >>> FRAC_BITS;
    int_sum  = 52'($signed({1'b0, integ_r})) + 52'(int_term);
    if (int_sum < 52'sd0) begin
      sum_nxt = '0;
    end else if (int_sum > S32Max) begin
      sum_nxt = '1;
    end else begin
      sum_nxt = int_sum[30:0];
    end
  end

  // latch updates and result assembly
  always_comb begin
    trip      = $signed({1'b0, sum_r}) > integral_limit_r;
    fault_nxt = fault_r;
    pwm_nxt   = pwm_r;
    integ_nxt = integ_r;
    if (post_over) begin
      fault_nxt[cmd.post_op[1:0]] = 1'b1;
      pwm_nxt                     = 1'b1;
    end
    if (cmd.commit) begin
      if (trip) begin
        fault_nxt = '0;
        pwm_nxt   = 1'b1;
        integ_nxt = '0;
      end else begin
        integ_nxt = sum_r;
      end
    end
    out_nxt.fault_bits     = fault_nxt;
    out_nxt.pwm_off        = pwm_nxt;
    out_nxt.integral_trip  = trip;
    out_nxt.coil_current   = il_r;
    out_nxt.integral_value = integ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_limit_r     <= CURRENT_LIMIT_RST;
      in_current_limit_r  <= IN_CURRENT_LIMIT_RST;
      in_voltage_limit_r  <= IN_VOLTAGE_LIMIT_RST;
      out_voltage_limit_r <= OUT_VOLTAGE_LIMIT_RST;
      current_nominal_r   <= CURRENT_NOMINAL_RST;
      integral_limit_r    <= INTEGRAL_LIMIT_RST;
      current_gain_r      <= CURRENT_GAIN_RST;
      sample_period_r     <= SAMPLE_PERIOD_RST;
      integ_r             <= '0;
      fault_r             <= '0;
      pwm_r               <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CURRENT_LIMIT:     current_limit_r     <= $signed(cfg_wdata);
          CFG_IN_CURRENT_LIMIT:  in_current_limit_r  <= $signed(cfg_wdata);
          CFG_IN_VOLTAGE_LIMIT:  in_voltage_limit_r  <= $signed(cfg_wdata);
          CFG_OUT_VOLTAGE_LIMIT: out_voltage_limit_r <= $signed(cfg_wdata);
          CFG_CURRENT_NOMINAL:   current_nominal_r   <= $signed(cfg_wdata);
          CFG_INTEGRAL_LIMIT:    integral_limit_r    <= $signed(cfg_wdata);
          CFG_CURRENT_GAIN:      current_gain_r      <= $signed(cfg_wdata);
          CFG_SAMPLE_PERIOD:     sample_period_r     <= cfg_wdata[16:0];
          default: ;
        endcase
      end
      integ_r <= integ_nxt;
      fault_r <= fault_nxt;
      pwm_r   <= pwm_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= in_data;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.post_en && (cmd.post_op == OP_IL)) begin
      il_r   <= post_val;
      diff_r <= 33'(post_val) - 33'(current_nominal_r);
    end
    if (cmd.post_en && (cmd.post_op == OP_INT)) begin
      sum_r <= sum_nxt;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
`default_nettype wire

>>> rtl/converter_fault_protection.sv
// top level of the converter fault protection block
// a new sample set is taken only while idle or as the previous set commits its result;
// each set makes five passes through the shared 33x18 multiplier, then the
// integrator sum and commit steps
// reset: limits, gains and sample period to defaults; integrator, faults and
// pwm-off latch cleared; no result pending
`timescale 1ns / 1ps
`default_nettype none
module converter_fault_protection
  import cfp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output out_t                  out_data
);

  cmd_t cmd;
  sts_t sts;

  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfp_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> dv/tb_converter_fault_protection.sv
`timescale 1ns / 1ps
// self-checking testbench for converter_fault_protection: directed and random sample sets
module tb_converter_fault_protection;
  import cfp_pkg::*;

  localparam int     FRAC           = FRAC_BITS_DEF;
  localparam longint S32_MAX        = 64'sd2147483647;
  localparam longint S32_MIN        = -64'sd2147483648;
  localparam longint VOUT_GAIN      = -(((longint'(11) <<< FRAC) + 5850 / 2) / 5850);
  localparam longint VOUT_OFFSET    = ((longint'(502) <<< FRAC) + 5 / 2) / 5;
  localparam longint VIN_GAIN       = ((longint'(12491) <<< FRAC) + 500000 / 2) / 500000;
  localparam longint IIN_GAIN       = ((longint'(9897) <<< FRAC) + 10000000 / 2) / 10000000;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     DRAIN_CYCLES   = 20;
  localparam int     RANDOM_PHASES  = 9;
  localparam int     SETS_PER_PHASE = 50;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;

  converter_fault_protection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // protection state as the block should hold it
  longint      integ_q     = 0;
  logic [3:0]  fault_q     = '0;
  logic        pwm_q       = 1'b0;
  logic [31:0] cfg_shadow [8];
  logic [31:0] plan_regs [8];

  in_t  pending_sets[$];
  out_t expected_results[$];

  int         fail_count    = 0;
  int         sets_sent     = 0;
  int         results_seen  = 0;
  int         trip_count    = 0;
  int         settings_used = 1;
  int         idle_cycles   = 0;
  int         gap_left      = 0;
  int         stall_left    = 0;
  logic [3:0] faults_seen   = '0;
  bit         quiet         = 1'b0;

  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic out_t protect_step(input in_t s);
    longint il, iin, vin, vout, sum;
    out_t   r;
    il   = sat32(longint'(signed'(cfg_shadow[CFG_CURRENT_GAIN])) * longint'(s.adc_coil_current));
    iin  = sat32(IIN_GAIN * longint'(s.adc_in_current));
    vin  = sat32(VIN_GAIN * longint'(s.adc_in_voltage));
    vout = sat32(VOUT_GAIN * longint'(s.adc_out_voltage) + VOUT_OFFSET);
    if (il > longint'(signed'(cfg_shadow[CFG_CURRENT_LIMIT]))) begin
      fault_q[0] = 1'b1;
      pwm_q      = 1'b1;
    end
    if (iin > longint'(signed'(cfg_shadow[CFG_IN_CURRENT_LIMIT]))) begin
      fault_q[1] = 1'b1;
      pwm_q      = 1'b1;
    end
    if (vin > longint'(signed'(cfg_shadow[CFG_IN_VOLTAGE_LIMIT]))) begin
      fault_q[2] = 1'b1;
      pwm_q      = 1'b1;
    end
    if (vout > longint'(signed'(cfg_shadow[CFG_OUT_VOLTAGE_LIMIT]))) begin
      fault_q[3] = 1'b1;
      pwm_q      = 1'b1;
    end
    faults_seen |= fault_q;
    sum = integ_q + (((il - longint'(signed'(cfg_shadow[CFG_CURRENT_NOMINAL])))
                     * longint'(cfg_shadow[CFG_SAMPLE_PERIOD][16:0])) >>> FRAC);
    if (sum < 0) sum = 0;
    if (sum > S32_MAX) sum = S32_MAX;
    r.integral_trip = 1'b0;
    if (sum > longint'(signed'(cfg_shadow[CFG_INTEGRAL_LIMIT]))) begin
      sum             = 0;
      r.integral_trip = 1'b1;
      pwm_q           = 1'b1;
      fault_q         = '0;
      trip_count++;
    end
    integ_q          = sum;
    r.fault_bits     = fault_q;
    r.pwm_off        = pwm_q;
    r.coil_current   = il[31:0];
    r.integral_value = sum[30:0];
    return r;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [11:0] pick_adc();
    case ($urandom_range(0, 9))
      0:       return 12'h000;
      1:       return 12'hfff;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic in_t mk_set(input logic [11:0] vout, input logic [11:0] il,
                                 input logic [11:0] vin, input logic [11:0] iin);
    in_t s;
    s.adc_out_voltage  = vout;
    s.adc_coil_current = il;
    s.adc_in_voltage   = vin;
    s.adc_in_current   = iin;
    return s;
  endfunction

  function automatic logic [31:0] pick_reg(input cfg_idx_t idx);
    int roll;
    roll = $urandom_range(0, 9);
    case (idx)
      CFG_CURRENT_GAIN: begin
        if (roll == 0) return 32'h8000_0000;
        if (roll == 1) return 32'h7fff_ffff;
        if (roll == 2) return $urandom();
        if (roll == 3) return 32'd0 - $urandom_range(1, 3000);
        return $urandom_range(0, 3000);
      end
      CFG_INTEGRAL_LIMIT: begin
        if (roll == 0) return 32'h8000_0000 | $urandom();
        if (roll == 1) return 32'h7fff_ffff;
        if (roll == 2) return 32'h0;
        return $urandom_range(0, 32'd1 << 22);
      end
      CFG_SAMPLE_PERIOD: begin
        if (roll == 0) return 32'h0;
        if (roll == 1) return 32'd65536;
        if (roll == 2) return 32'h0001_ffff;
        if (roll == 3) return $urandom();
        return $urandom_range(1, 65536);
      end
      default: begin
        if (roll == 0) return 32'h8000_0000;
        if (roll == 1) return 32'h7fff_ffff;
        if (roll == 2) return $urandom();
        return $urandom_range(0, 32'd7_000_000);
      end
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  task automatic wait_drained();
    while (pending_sets.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic load_settings();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int r = 0; r < 8; r++) begin
      @(posedge clk);
      cfg_we        <= 1'b1;
      cfg_index     <= cfg_idx_t'(r);
      cfg_wdata     <= plan_regs[r];
      cfg_shadow[r]  = plan_regs[r];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_random_sets(input int count);
    for (int k = 0; k < count; k++)
      pending_sets.push_back(mk_set(pick_adc(), pick_adc(), pick_adc(), pick_adc()));
  endtask

  // input side: one transfer per accepted set, random gaps between sets outside quiet phases
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(protect_step(in_data));
        sets_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_sets.size() != 0) begin
          in_data  <= pending_sets.pop_front();
          in_valid <= 1'b1;
          gap_left  = quiet ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing expected: %h", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.fault_bits !== want.fault_bits)
            note_failure($sformatf("fault_bits exp %b got %b",
                                   want.fault_bits, out_data.fault_bits));
          if (out_data.pwm_off !== want.pwm_off)
            note_failure($sformatf("pwm_off exp %b got %b", want.pwm_off, out_data.pwm_off));
          if (out_data.integral_trip !== want.integral_trip)
            note_failure($sformatf("integral_trip exp %b got %b",
                                   want.integral_trip, out_data.integral_trip));
          if (out_data.coil_current !== want.coil_current)
            note_failure($sformatf("coil_current exp %0d got %0d",
                                   want.coil_current, out_data.coil_current));
          if (out_data.integral_value !== want.integral_value)
            note_failure($sformatf("integral_value exp %0d got %0d",
                                   want.integral_value, out_data.integral_value));
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        out_stall  <= 1'b1;
        stall_left  = idle_len();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cfg_shadow[CFG_CURRENT_LIMIT]     = CURRENT_LIMIT_RST;
    cfg_shadow[CFG_IN_CURRENT_LIMIT]  = IN_CURRENT_LIMIT_RST;
    cfg_shadow[CFG_IN_VOLTAGE_LIMIT]  = IN_VOLTAGE_LIMIT_RST;
    cfg_shadow[CFG_OUT_VOLTAGE_LIMIT] = OUT_VOLTAGE_LIMIT_RST;
    cfg_shadow[CFG_CURRENT_NOMINAL]   = CURRENT_NOMINAL_RST;
    cfg_shadow[CFG_INTEGRAL_LIMIT]    = INTEGRAL_LIMIT_RST;
    cfg_shadow[CFG_CURRENT_GAIN]      = CURRENT_GAIN_RST;
    cfg_shadow[CFG_SAMPLE_PERIOD]     = {15'd0, SAMPLE_PERIOD_RST};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // default settings: field extremes and each threshold from just below to just above
    pending_sets.push_back(mk_set(12'd2000, 12'd0, 12'd0, 12'd0));
    pending_sets.push_back(mk_set(12'hfff, 12'd4032, 12'd3603, 12'd3024));
    pending_sets.push_back(mk_set(12'd214, 12'd4032, 12'd0, 12'd0));
    pending_sets.push_back(mk_set(12'd2000, 12'd4033, 12'd0, 12'd0));
    pending_sets.push_back(mk_set(12'd2000, 12'd0, 12'd0, 12'd3025));
    pending_sets.push_back(mk_set(12'd2000, 12'd0, 12'd3604, 12'd0));
    pending_sets.push_back(mk_set(12'd213, 12'd0, 12'd0, 12'd0));
    pending_sets.push_back(mk_set(12'd0, 12'hfff, 12'hfff, 12'hfff));
    pending_sets.push_back(mk_set(12'hfff, 12'd0, 12'hfff, 12'd0));
    pending_sets.push_back(mk_set(12'haaa, 12'h555, 12'haaa, 12'h555));
    pending_sets.push_back(mk_set(12'h555, 12'haaa, 12'h555, 12'haaa));
    pending_sets.push_back(mk_set(12'd0, 12'd0, 12'd0, 12'd0));

    // positive extremes: gain saturates high, integrator saturates, period above 65536
    plan_regs[CFG_CURRENT_LIMIT]     = 32'h7fff_ffff;
    plan_regs[CFG_IN_CURRENT_LIMIT]  = 32'h7fff_ffff;
    plan_regs[CFG_IN_VOLTAGE_LIMIT]  = 32'h7fff_ffff;
    plan_regs[CFG_OUT_VOLTAGE_LIMIT] = 32'h7fff_ffff;
    plan_regs[CFG_CURRENT_NOMINAL]   = 32'h8000_0000;
    plan_regs[CFG_INTEGRAL_LIMIT]    = 32'h7fff_ffff;
    plan_regs[CFG_CURRENT_GAIN]      = 32'h7fff_ffff;
    plan_regs[CFG_SAMPLE_PERIOD]     = 32'h0001_ffff;
    load_settings();
    queue_random_sets(30);

    // negative extremes: every limit exceeded, negative integral limit trips each set
    plan_regs[CFG_CURRENT_LIMIT]     = 32'h8000_0000;
    plan_regs[CFG_IN_CURRENT_LIMIT]  = 32'h8000_0000;
    plan_regs[CFG_IN_VOLTAGE_LIMIT]  = 32'h8000_0000;
    plan_regs[CFG_OUT_VOLTAGE_LIMIT] = 32'h8000_0000;
    plan_regs[CFG_CURRENT_NOMINAL]   = 32'h7fff_ffff;
    plan_regs[CFG_INTEGRAL_LIMIT]    = 32'h8000_0000;
    plan_regs[CFG_CURRENT_GAIN]      = 32'h8000_0000;
    plan_regs[CFG_SAMPLE_PERIOD]     = 32'h0;
    load_settings();
    queue_random_sets(30);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int r = 0; r < 8; r++) plan_regs[r] = pick_reg(cfg_idx_t'(r));
      load_settings();
      quiet = ($urandom_range(0, 3) == 0);
      queue_random_sets(SETS_PER_PHASE);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d of %0d sample sets under %0d register settings",
             results_seen, sets_sent, settings_used);
    $display("integrator trips %0d, fault bits reached %b, mismatches %0d",
             trip_count, faults_seen, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
